// File: rtl/smd_pkg.sv
package smd_pkg;

  // Width of a store address inside a micro-op; covers the largest store.
  localparam int UOP_ADDR_BITS = 4;

  // Reset value of the matrix size register.
  localparam logic [2:0] MATRIX_SIZE_RESET = 3'd4;

  // Register index of matrix_size, as seen on the word address bit.
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // Operation kinds of the shared multiply-accumulate unit.
  //   OP_EE_M : minor accumulator += element * element
  //   OP_EE_D : determinant       += element * element
  //   OP_EM_D : determinant       += element * minor
  //   OP_SAVE : saved minor        = minor accumulator
  //   OP_TM_D : determinant       += saved minor * minor
  typedef enum logic [2:0] {
    OP_EE_M,
    OP_EE_D,
    OP_EM_D,
    OP_SAVE,
    OP_TM_D
  } op_kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_HOLD
  } seq_state_t;

  // One micro-op of the determinant program.
  typedef struct packed {
    op_kind_t                 kind;
    logic                     neg;
    logic                     clr;
    logic                     last;
    logic [UOP_ADDR_BITS-1:0] a0;
    logic [UOP_ADDR_BITS-1:0] a1;
  } uop_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic     mul_en;
    logic     acc_en;
    op_kind_t kind;
    logic     neg;
    logic     clr;
  } mac_ctrl_t;

  // Store address of element (r, c) in row-major order for the given order.
  function automatic logic [UOP_ADDR_BITS-1:0] elem_addr(input logic [2:0] order,
                                                         input logic [1:0] r,
                                                         input logic [1:0] c);
    logic [UOP_ADDR_BITS-1:0] addr;
    case (order)
      3'd2: addr = {2'b00, r[0], c[0]};
      3'd3: addr = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
      default: addr = {r, c};
    endcase
    return addr;
  endfunction

  // Lower column of the k-th column pair of a 4x4 expansion.
  function automatic logic [1:0] pair_lo(input logic [2:0] k);
    logic [1:0] col;
    case (k)
      3'd0, 3'd1, 3'd2: col = 2'd0;
      3'd3, 3'd4:       col = 2'd1;
      default:          col = 2'd2;
    endcase
    return col;
  endfunction

  // Upper column of the k-th column pair of a 4x4 expansion.
  function automatic logic [1:0] pair_hi(input logic [2:0] k);
    logic [1:0] col;
    case (k)
      3'd0:       col = 2'd1;
      3'd1, 3'd3: col = 2'd2;
      default:    col = 2'd3;
    endcase
    return col;
  endfunction

  // Index of the last step within one term of the program.
  function automatic logic [2:0] step_last(input logic [2:0] order);
    logic [2:0] s;
    case (order)
      3'd2:    s = 3'd1;
      3'd3:    s = 3'd2;
      default: s = 3'd5;
    endcase
    return s;
  endfunction

  // Micro-op for a given order, term and step of the determinant program.
  function automatic uop_t uop_fetch(input logic [2:0] order,
                                     input logic [2:0] term,
                                     input logic [2:0] step);
    uop_t       u;
    logic [2:0] comp;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] cc;
    logic [1:0] cd;
    u      = '0;
    u.kind = OP_SAVE;
    comp   = 3'd5 - term;
    ca     = pair_lo(term);
    cb     = pair_hi(term);
    cc     = pair_lo(comp);
    cd     = pair_hi(comp);
    case (order)
      3'd2: begin
        // a00*a11 - a01*a10 straight into the determinant.
        u.kind = OP_EE_D;
        if (step == 3'd0) begin
          u.clr = 1'b1;
          u.a0  = elem_addr(order, 2'd0, 2'd0);
          u.a1  = elem_addr(order, 2'd1, 2'd1);
        end else begin
          u.neg  = 1'b1;
          u.last = 1'b1;
          u.a0   = elem_addr(order, 2'd0, 2'd1);
          u.a1   = elem_addr(order, 2'd1, 2'd0);
        end
      end
      3'd3: begin
        // Cofactor expansion along row zero; minors from rows one and two.
        ca = (term == 3'd0) ? 2'd1 : 2'd0;
        cb = (term == 3'd2) ? 2'd1 : 2'd2;
        case (step)
          3'd0: begin
            u.kind = OP_EE_M;
            u.clr  = 1'b1;
            u.a0   = elem_addr(order, 2'd1, ca);
            u.a1   = elem_addr(order, 2'd2, cb);
          end
          3'd1: begin
            u.kind = OP_EE_M;
            u.neg  = 1'b1;
            u.a0   = elem_addr(order, 2'd1, cb);
            u.a1   = elem_addr(order, 2'd2, ca);
          end
          default: begin
            u.kind = OP_EM_D;
            u.neg  = (term == 3'd1);
            u.clr  = (term == 3'd0);
            u.last = (term == 3'd2);
            u.a0   = elem_addr(order, 2'd0, term[1:0]);
          end
        endcase
      end
      default: begin
        // Laplace expansion: top-row minor times complementary bottom-row minor.
        case (step)
          3'd0: begin
            u.kind = OP_EE_M;
            u.clr  = 1'b1;
            u.a0   = elem_addr(order, 2'd0, ca);
            u.a1   = elem_addr(order, 2'd1, cb);
          end
          3'd1: begin
            u.kind = OP_EE_M;
            u.neg  = 1'b1;
            u.a0   = elem_addr(order, 2'd0, cb);
            u.a1   = elem_addr(order, 2'd1, ca);
          end
          3'd2: begin
            u.kind = OP_SAVE;
          end
          3'd3: begin
            u.kind = OP_EE_M;
            u.clr  = 1'b1;
            u.a0   = elem_addr(order, 2'd2, cc);
            u.a1   = elem_addr(order, 2'd3, cd);
          end
          3'd4: begin
            u.kind = OP_EE_M;
            u.neg  = 1'b1;
            u.a0   = elem_addr(order, 2'd2, cd);
            u.a1   = elem_addr(order, 2'd3, cc);
          end
          default: begin
            u.kind = OP_TM_D;
            u.neg  = (term == 3'd1) || (term == 3'd4);
            u.clr  = (term == 3'd0);
            u.last = (term == 3'd5);
          end
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

// File: rtl/smd_cfg_regs.sv
module smd_cfg_regs #(
  parameter int MAX_ORDER = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  order,
  output logic        size_wr
);
  import smd_pkg::*;

  logic [2:0] size_r;
  logic [2:0] size_nxt;
  logic       sel_size;

  // Word address decode; the only register sits at word zero.
  assign sel_size = (paddr[2] == REG_MATRIX_SIZE);
  assign pready   = 1'b1;
  assign size_wr  = psel && penable && pwrite && pready && sel_size;

  // Register write.
  always_comb begin
    size_nxt = size_r;
    if (size_wr) begin
      size_nxt = pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= MATRIX_SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  // Read back the raw register value.
  assign prdata = sel_size ? {29'd0, size_r} : 32'd0;

  // Clamp the programmed size to the supported orders.
  always_comb begin
    if (size_r < 3'd2) begin
      order = 3'd2;
    end else if (size_r > 3'(MAX_ORDER)) begin
      order = 3'(MAX_ORDER);
    end else begin
      order = size_r;
    end
  end

endmodule

// File: rtl/smd_store.sv
module smd_store #(
  parameter int ELEMENT_BITS = 12,
  parameter int DEPTH        = 16,
  parameter int ADDR_BITS    = 4
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_BITS-1:0]           wr_addr,
  input  logic signed [ELEMENT_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0]           rd_addr0,
  input  logic [ADDR_BITS-1:0]           rd_addr1,
  output logic signed [ELEMENT_BITS-1:0] rd_data0,
  output logic signed [ELEMENT_BITS-1:0] rd_data1
);

  logic [ELEMENT_BITS-1:0] mem_r [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_data0_r;
  logic [ELEMENT_BITS-1:0] rd_data1_r;

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data0_r <= mem_r[rd_addr0];
    rd_data1_r <= mem_r[rd_addr1];
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// File: rtl/smd_mac.sv
module smd_mac #(
  parameter int ELEMENT_BITS = 12
) (
  input  logic                               clk,
  input  smd_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [ELEMENT_BITS-1:0]     rd_data0,
  input  logic signed [ELEMENT_BITS-1:0]     rd_data1,
  output logic signed [4*ELEMENT_BITS+1:0]   det
);
  import smd_pkg::*;

  localparam int MW = 2 * ELEMENT_BITS + 1;
  localparam int DW = 2 * MW;

  logic signed [MW-1:0] ext0;
  logic signed [MW-1:0] ext1;
  logic signed [MW-1:0] opa;
  logic signed [MW-1:0] opb;
  logic signed [MW-1:0] m_r;
  logic signed [MW-1:0] m_nxt;
  logic signed [MW-1:0] t_r;
  logic signed [MW-1:0] t_nxt;
  logic signed [DW-1:0] prod_r;
  logic signed [DW-1:0] prod_nxt;
  logic signed [DW-1:0] d_r;
  logic signed [DW-1:0] d_nxt;
  logic signed [DW-1:0] addend;

  // Operand selection for the shared multiplier.
  always_comb begin
    ext0 = MW'(rd_data0);
    ext1 = MW'(rd_data1);
    opa  = (ctrl.kind == OP_TM_D) ? t_r : ext0;
    opb  = ((ctrl.kind == OP_EE_M) || (ctrl.kind == OP_EE_D)) ? ext1 : m_r;
  end

  // Multiply phase: product register, or save the minor for a 4x4 term.
  always_comb begin
    prod_nxt = prod_r;
    t_nxt    = t_r;
    if (ctrl.mul_en) begin
      prod_nxt = DW'(opa) * DW'(opb);
      if (ctrl.kind == OP_SAVE) begin
        t_nxt = m_r;
      end
    end
  end

  // Accumulate phase into the minor or the determinant accumulator.
  always_comb begin
    addend = ctrl.neg ? -prod_r : prod_r;
    m_nxt  = m_r;
    d_nxt  = d_r;
    if (ctrl.acc_en) begin
      case (ctrl.kind)
        OP_EE_M: m_nxt = (ctrl.clr ? MW'(0) : m_r) + MW'(addend);
        OP_EE_D, OP_EM_D, OP_TM_D: d_nxt = (ctrl.clr ? DW'(0) : d_r) + addend;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    m_r    <= m_nxt;
    d_r    <= d_nxt;
  end

  assign det = d_r;

endmodule

// File: rtl/smd_seq.sv
module smd_seq #(
  parameter int ADDR_BITS = 4,
  parameter int LOAD_BITS = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [2:0]               order,
  input  logic                     cfg_wr,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     wr_en,
  output logic [ADDR_BITS-1:0]     wr_addr,
  output logic [ADDR_BITS-1:0]     rd_addr0,
  output logic [ADDR_BITS-1:0]     rd_addr1,
  output smd_pkg::mac_ctrl_t       ctrl,
  input  logic                     out_free,
  output logic                     out_load
);
  import smd_pkg::*;

  seq_state_t           state_r;
  seq_state_t           state_nxt;
  logic [LOAD_BITS-1:0] load_idx_r;
  logic [LOAD_BITS-1:0] load_idx_nxt;
  logic [LOAD_BITS-1:0] total;
  logic [2:0]           term_r;
  logic [2:0]           term_nxt;
  logic [2:0]           step_r;
  logic [2:0]           step_nxt;
  uop_t                 uop;

  // Element count of the configured matrix.
  always_comb begin
    case (order)
      3'd2:    total = LOAD_BITS'(4);
      3'd3:    total = LOAD_BITS'(9);
      default: total = LOAD_BITS'(16);
    endcase
  end

  // Current micro-op and its store addresses.
  assign uop      = uop_fetch(order, term_r, step_r);
  assign rd_addr0 = uop.a0[ADDR_BITS-1:0];
  assign rd_addr1 = uop.a1[ADDR_BITS-1:0];
  assign wr_addr  = load_idx_r[ADDR_BITS-1:0];

  // Next state and control outputs.
  always_comb begin
    state_nxt    = state_r;
    load_idx_nxt = load_idx_r;
    term_nxt     = term_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    wr_en        = 1'b0;
    out_load     = 1'b0;
    ctrl         = '0;
    ctrl.kind    = uop.kind;
    ctrl.neg     = uop.neg;
    ctrl.clr     = uop.clr;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en = 1'b1;
          if (load_idx_r == total - LOAD_BITS'(1)) begin
            load_idx_nxt = '0;
            term_nxt     = 3'd0;
            step_nxt     = 3'd0;
            state_nxt    = ST_READ;
          end else begin
            load_idx_nxt = load_idx_r + LOAD_BITS'(1);
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc_en = 1'b1;
        if (uop.last) begin
          state_nxt = ST_HOLD;
        end else begin
          if (step_r == step_last(order)) begin
            step_nxt = 3'd0;
            term_nxt = term_r + 3'd1;
          end else begin
            step_nxt = step_r + 3'd1;
          end
          state_nxt = ST_READ;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // A size write discards a partly loaded matrix.
    if (cfg_wr) begin
      load_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_idx_r <= '0;
      term_r     <= 3'd0;
      step_r     <= 3'd0;
    end else begin
      state_r    <= state_nxt;
      load_idx_r <= load_idx_nxt;
      term_r     <= term_nxt;
      step_r     <= step_nxt;
    end
  end

endmodule

// File: rtl/small_matrix_determinant_unit.sv
// Determinant of a square integer matrix of order two, three or four.
//
// The order is written through the APB port (matrix_size, word 0); the value
// is clamped to 2..MAX_ORDER, and a write restarts the matrix load. Elements
// arrive on the in_ stream one beat each in row-major order and are accepted
// one per cycle while a matrix is being loaded. The beat that carries the
// last element starts the computation: a sequencer runs a fixed program of
// multiply-accumulate operations through one shared multiplier, each one
// passing through a store read, a multiply and an accumulate state. That
// is 2 operations for order two, 9 for order three and 36 for order four,
// and in_tready stays low until the result enters the output register.
// A matrix of order n is loaded as n*n element beats. The result sits in
// an output register; while the receiver stalls the next matrix can still
// be loaded, and only a finished computation waits for the register to
// free up. Reset (rst_n, synchronous) empties the output, sets the order
// to four and restarts the load; store contents are not cleared and every
// entry is written before it is read.
module small_matrix_determinant_unit #(
  parameter int ELEMENT_BITS = 12,
  parameter int MAX_ORDER    = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: element_value in [ELEMENT_BITS-1:0], zero padding above.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((ELEMENT_BITS+7)/8)*8-1:0]      in_tdata,
  // out_tdata: determinant in [4*ELEMENT_BITS+1:0], zero padding above.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((4*ELEMENT_BITS+2+7)/8)*8-1:0]  out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [2:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import smd_pkg::*;

  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int LOAD_BITS = $clog2(DEPTH + 1);
  localparam int DET_BITS  = 4 * ELEMENT_BITS + 2;
  localparam int OUT_W     = ((DET_BITS + 7) / 8) * 8;

  logic [2:0]                     order;
  logic                           size_wr;
  logic                           wr_en;
  logic [ADDR_BITS-1:0]           wr_addr;
  logic [ADDR_BITS-1:0]           rd_addr0;
  logic [ADDR_BITS-1:0]           rd_addr1;
  logic signed [ELEMENT_BITS-1:0] rd_data0;
  logic signed [ELEMENT_BITS-1:0] rd_data1;
  mac_ctrl_t                      ctrl;
  logic signed [DET_BITS-1:0]     det;
  logic                           out_free;
  logic                           out_load;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [DET_BITS-1:0]            out_data_r;
  logic [DET_BITS-1:0]            out_data_nxt;

  smd_cfg_regs #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .order   (order),
    .size_wr (size_wr)
  );

  smd_seq #(
    .ADDR_BITS (ADDR_BITS),
    .LOAD_BITS (LOAD_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .order    (order),
    .cfg_wr   (size_wr),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .ctrl     (ctrl),
    .out_free (out_free),
    .out_load (out_load)
  );

  smd_store #(
    .ELEMENT_BITS (ELEMENT_BITS),
    .DEPTH        (DEPTH),
    .ADDR_BITS    (ADDR_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_tdata[ELEMENT_BITS-1:0]),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  smd_mac #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .det      (det)
  );

  // Output register: free when empty or when the current beat is taken.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = det;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

// File: rtl/smd_checker.sv
module smd_checker #(
  parameter int OUT_W = 56
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // Out of reset the block is ready for elements and has no result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("wrong state after reset");

  // The input side closes only after an element beat starts a computation.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input closed without an accepted beat");

  // A new result appears only at the end of a computation.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while loading elements");

endmodule

bind small_matrix_determinant_unit smd_checker #(
  .OUT_W ($bits(out_tdata))
) u_smd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smd_pkg::*;

  localparam int ELEM_W        = 12;
  localparam int MAX_ORDER     = 4;
  localparam int IN_W          = ((ELEM_W + 7) / 8) * 8;
  localparam int DET_W         = 4 * ELEM_W + 2;
  localparam int OUT_W         = ((DET_W + 7) / 8) * 8;
  localparam int TARGET_ITEMS  = 1050;
  localparam int SETTLE_CYCLES = 130;
  localparam int HOLD_CYCLES   = 700;
  localparam int STALL_LIMIT   = 3000;

  // Ways of filling a matrix with element values.
  typedef enum int {
    FILL_WIDE,
    FILL_EDGE,
    FILL_TINY,
    FILL_SINGULAR
  } fill_style_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // in_tdata: element_value [11:0], zero padding [15:12].
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  // out_tdata: determinant [49:0], zero padding [55:50].
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [2:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Predictor state: the size register, the element store and the load counter.
  logic [2:0]        size_reg = MATRIX_SIZE_RESET;
  logic [ELEM_W-1:0] matrix_store [16];
  int                load_count = 0;
  logic [DET_W-1:0]  det_q [$];

  // Run bookkeeping.
  int fail_count       = 0;
  int elements_taken   = 0;
  int dets_by_order [5] = '{default: 0};
  int dets_checked     = 0;
  int discarded_loads  = 0;
  int stall_count      = 0;
  int hold_request     = 0;
  int burst_left       = 0;
  bit pace_bursty      = 1'b1;

  small_matrix_determinant_unit #(
    .ELEMENT_BITS (ELEM_W),
    .MAX_ORDER    (MAX_ORDER)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Out-of-range sizes fold onto the nearest supported order.
  function automatic int clamp_order(input logic [2:0] size);
    if (size < 3'd2) return 2;
    if (size > MAX_ORDER) return MAX_ORDER;
    return int'(size);
  endfunction

  function automatic longint entry_at(input int n, input int r, input int c);
    return longint'($signed(matrix_store[(r * n + c) & 15]));
  endfunction

  function automatic longint minor2(input int n, input int r0, input int r1,
                                    input int c0, input int c1);
    return entry_at(n, r0, c0) * entry_at(n, r1, c1) - entry_at(n, r0, c1) * entry_at(n, r1, c0);
  endfunction

  // Exact determinant of the stored matrix, wrapped to the output width.
  function automatic logic [DET_W-1:0] determinant_of(input int n);
    longint d;
    if (n == 2) begin
      d = minor2(n, 0, 1, 0, 1);
    end else if (n == 3) begin
      d = entry_at(n, 0, 0) * minor2(n, 1, 2, 1, 2)
        - entry_at(n, 0, 1) * minor2(n, 1, 2, 0, 2)
        + entry_at(n, 0, 2) * minor2(n, 1, 2, 0, 1);
    end else begin
      d = minor2(n, 0, 1, 0, 1) * minor2(n, 2, 3, 2, 3)
        - minor2(n, 0, 1, 0, 2) * minor2(n, 2, 3, 1, 3)
        + minor2(n, 0, 1, 0, 3) * minor2(n, 2, 3, 1, 2)
        + minor2(n, 0, 1, 1, 2) * minor2(n, 2, 3, 0, 3)
        - minor2(n, 0, 1, 1, 3) * minor2(n, 2, 3, 0, 2)
        + minor2(n, 0, 1, 2, 3) * minor2(n, 2, 3, 0, 1);
    end
    return d[DET_W-1:0];
  endfunction

  // Store one element; the last one of a matrix queues its determinant.
  function automatic void load_element(input logic [ELEM_W-1:0] value);
    int n;
    int slot;
    n    = clamp_order(size_reg);
    slot = load_count;
    if (slot >= n * n) slot = 0;
    matrix_store[slot & 15] = value;
    if (slot + 1 < n * n) begin
      load_count = slot + 1;
    end else begin
      load_count = 0;
      det_q.push_back(determinant_of(n));
      dets_by_order[n]++;
    end
  endfunction

  // Follow every accepted beat: check results, apply register writes, predict.
  always @(posedge clk) begin
    logic [DET_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (det_q.size() == 0) begin
          $error("determinant: expected none, actual %0d", $signed(out_tdata[DET_W-1:0]));
          fail_count++;
        end else begin
          want = det_q.pop_front();
          dets_checked++;
          if (out_tdata[DET_W-1:0] !== want) begin
            $error("determinant: expected %0d, actual %0d",
                   $signed(want), $signed(out_tdata[DET_W-1:0]));
            fail_count++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_MATRIX_SIZE, 2'b00}) begin
        size_reg   = cfg_pwdata[2:0];
        load_count = 0;
      end
      if (in_tvalid && in_tready) begin
        load_element(in_tdata[ELEM_W-1:0]);
        elements_taken++;
      end
    end
  end

  // Receiver: a held-off stretch on request, otherwise a changing stall pattern.
  always @(posedge clk) begin
    int hold_left;
    int pattern_left;
    int stall_mode;
    int run_left;
    bit run_ready;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      hold_left    = 0;
      pattern_left = 0;
      stall_mode   = 0;
      run_left     = 0;
      run_ready    = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_tready  <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        stall_mode   = $urandom_range(0, 3);
      end
      pattern_left--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_ready = ~run_ready;
            run_left  = $urandom_range(1, 12);
          end
          run_left--;
          out_tready <= run_ready;
        end
      endcase
    end
  end

  // Watchdog: too long without any beat or register write means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("Watchdog: %0d cycles without a beat, %0d results pending.",
                 stall_count, det_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one element and hold it until the beat is taken.
  task automatic send_element(input logic [ELEM_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = pace_bursty ? $urandom_range(1, 16) : 64;
      gap        = pace_bursty ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - ELEM_W){1'b0}}, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every queued determinant has come out.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (det_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Full quiesce before a register write: results out, compute surely done.
  task automatic settle_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write of matrix_size; upper data bits are don't-care.
  // It returns only after the predictor has picked up the new size, before any load.
  task automatic write_matrix_size(input logic [2:0] size);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_MATRIX_SIZE, 2'b00};
    cfg_pwdata  <= {29'($urandom_range(0, 32'h1fff_ffff)), size};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] pick_element(input fill_style_t style);
    case (style)
      FILL_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 12'h800;
          1: return 12'h7ff;
          2: return 12'h000;
          3: return 12'hfff;
          default: return 12'h001;
        endcase
      end
      FILL_TINY: return 12'($signed($urandom_range(0, 16)) - 8);
      default:   return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Send one whole matrix at the current order.
  task automatic send_matrix(input fill_style_t style);
    logic [ELEM_W-1:0] cells [16];
    int n;
    int k;
    n = clamp_order(size_reg);
    for (k = 0; k < n * n; k++) begin
      // A singular matrix repeats its second-to-last row as the last one.
      if (style == FILL_SINGULAR && k >= n * (n - 1)) cells[k] = cells[k - n];
      else cells[k] = pick_element(style == FILL_SINGULAR ? FILL_WIDE : style);
    end
    for (k = 0; k < n * n; k++) send_element(cells[k]);
  endtask

  task automatic send_list(input int count, input logic [ELEM_W-1:0] values [16]);
    int k;
    for (k = 0; k < count; k++) send_element(values[k]);
  endtask

  // Directed matrices at each order, with all-ones and sign-bit extremes,
  // out-of-range sizes and a partly loaded matrix thrown away by a write.
  task automatic test_directed_orders();
    logic [ELEM_W-1:0] vals [16];
    pace_bursty = 1'b0;
    write_matrix_size(3'd0);
    vals = '{0: 12'h7ff, 1: 12'h800, 2: 12'h800, 3: 12'h7ff, default: 12'h000};
    send_list(4, vals);
    settle_block();
    write_matrix_size(3'd3);
    vals = '{0: 12'h800, 1: 12'h7ff, 2: 12'h000, 3: 12'h001, 4: 12'hfff, 5: 12'h800,
             6: 12'h7ff, 7: 12'h000, 8: 12'h800, default: 12'h000};
    send_list(9, vals);
    // Partial load, discarded by the next write.
    vals = '{0: 12'h123, 1: 12'h800, 2: 12'h7ff, 3: 12'h456, default: 12'h000};
    send_list(4, vals);
    discarded_loads++;
    settle_block();
    write_matrix_size(3'd7);
    // Scaled Hadamard pattern gives a near-maximal determinant.
    vals = '{12'h800, 12'h800, 12'h800, 12'h800,
             12'h800, 12'h7ff, 12'h800, 12'h7ff,
             12'h800, 12'h800, 12'h7ff, 12'h7ff,
             12'h800, 12'h7ff, 12'h7ff, 12'h800};
    send_list(16, vals);
    settle_block();
  endtask

  // Random phases: every register value early on, then mostly legal orders.
  task automatic test_random_matrices();
    int phase;
    int n;
    logic [2:0] size;
    phase = 0;
    while (elements_taken < TARGET_ITEMS - 30) begin
      settle_block();
      if (phase < 8) size = phase[2:0];
      else if ($urandom_range(0, 9) < 7) size = 3'($urandom_range(2, 4));
      else size = 3'($urandom_range(0, 7));
      write_matrix_size(size);
      pace_bursty = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 6)) send_matrix(fill_style_t'($urandom_range(0, 3)));
      // Now and then an abandoned, partly loaded matrix.
      if ($urandom_range(0, 5) == 0) begin
        n = clamp_order(size_reg);
        repeat ($urandom_range(1, n * n - 1)) send_element(pick_element(FILL_WIDE));
        discarded_loads++;
      end
      phase++;
    end
    settle_block();
  endtask

  // Long receiver hold-off while the sender keeps offering, so the input
  // stalls; then a sender pause until every result is out.
  task automatic test_backpressure();
    write_matrix_size(3'd4);
    pace_bursty  = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (4) send_matrix(FILL_WIDE);
    settle_block();
    write_matrix_size(3'd3);
    pace_bursty = 1'b1;
    repeat (2) send_matrix(FILL_EDGE);
    wait_results();
    repeat (3) send_matrix(FILL_WIDE);
    settle_block();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_orders();
    test_backpressure();
    test_random_matrices();

    if (det_q.size() != 0) begin
      $error("determinant: %0d expected results never arrived", det_q.size());
      fail_count++;
    end
    $display("Covered %0d element beats at orders 2/3/4 with %0d/%0d/%0d determinants.",
             elements_taken, dets_by_order[2], dets_by_order[3], dets_by_order[4]);
    $display("Checked %0d results; %0d partial loads discarded by size writes.",
             dets_checked, discarded_loads);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/smd_pkg.sv
rtl/smd_cfg_regs.sv
rtl/smd_store.sv
rtl/smd_mac.sv
rtl/smd_seq.sv
rtl/small_matrix_determinant_unit.sv
rtl/smd_checker.sv
verif/testbench.sv
